// File: sv/fsx_pkg.sv
// Shared types and constants for the frame sum/xor checker.
// No dependencies; every other file imports this package.
package fsx_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned IndexW   = 9;
  localparam int unsigned VerdictW = 3;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  localparam logic [ByteW-1:0] StartByteRst = 8'h7E;
  localparam logic [ByteW-1:0] TypeByteRst  = 8'h0F;

  localparam logic REG_IDX_START = 1'b0;
  localparam logic REG_IDX_TYPE  = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TYPE,
    PH_LEN,
    PH_BODY,
    PH_SUM,
    PH_XOR
  } phase_e;

  typedef enum logic [VerdictW-1:0] {
    VERDICT_PASS  = 3'd0,
    VERDICT_HDR   = 3'd1,
    VERDICT_SHORT = 3'd2,
    VERDICT_SUM   = 3'd3,
    VERDICT_XOR   = 3'd4
  } verdict_e;

  typedef struct packed {
    logic [ByteW-1:0] start_byte;
    logic [ByteW-1:0] type_byte;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             first_of_frame;
  } item_t;

endpackage

// File: sv/fsx_if.sv
// Valid/ready channel interfaces for frame bytes and verdicts.
// Depends on fsx_pkg.
interface fsx_in_if
  import fsx_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             first_of_frame;

  modport source (output valid, data_byte, first_of_frame, input ready);
  modport sink (input valid, data_byte, first_of_frame, output ready);
endinterface

interface fsx_out_if
  import fsx_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [VerdictW-1:0] verdict;
  logic [ByteW-1:0]    computed_sum;
  logic [ByteW-1:0]    computed_xor;

  modport source (output valid, verdict, computed_sum, computed_xor, input ready);
  modport sink (input valid, verdict, computed_sum, computed_xor, output ready);
endinterface

// File: sv/fsx_cfg_regs.sv
// APB-style configuration registers: start byte and type byte.
// Depends on fsx_pkg.
module fsx_cfg_regs
  import fsx_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;
  logic reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_IDX_START: cfg_d.start_byte = pwdata[ByteW-1:0];
        REG_IDX_TYPE:  cfg_d.type_byte  = pwdata[ByteW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_IDX_START: prdata[ByteW-1:0] = cfg_q.start_byte;
      REG_IDX_TYPE:  prdata[ByteW-1:0] = cfg_q.type_byte;
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte <= StartByteRst;
      cfg_q.type_byte  <= TypeByteRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/fsx_in_stage.sv
// Input register: captures one byte transaction, refills in the cycle it drains.
// Depends on fsx_pkg and fsx_in_if.
module fsx_in_stage
  import fsx_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  fsx_in_if.sink    in_if,
  output logic      item_valid_o,
  output item_t     item_o,
  input  logic      item_take_i
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  assign in_if.ready = !valid_q || item_take_i;
  assign load        = in_if.valid && in_if.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (item_take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.data_byte      <= in_if.data_byte;
      item_q.first_of_frame <= in_if.first_of_frame;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// File: sv/fsx_frame_fsm.sv
// Frame parser: header check, running sum/xor, trailer compare, result register.
// Depends on fsx_pkg and fsx_out_if.
module fsx_frame_fsm
  import fsx_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      item_valid_i,
  input  item_t     item_i,
  output logic      item_take_o,
  fsx_out_if.source out_if
);

  phase_e            phase_q, phase_d;
  logic [IndexW-1:0] byte_index_q, byte_index_d;
  logic [ByteW-1:0]  frame_length_q, frame_length_d;
  logic [ByteW-1:0]  running_sum_q, running_sum_d;
  logic [ByteW-1:0]  running_xor_q, running_xor_d;
  logic              sum_failed_q, sum_failed_d;

  logic              out_valid_q, out_valid_d;
  verdict_e          verdict_q, verdict_d;
  logic [ByteW-1:0]  res_sum_q, res_sum_d;
  logic [ByteW-1:0]  res_xor_q, res_xor_d;

  logic              emit;
  logic [ByteW-1:0]  d;
  logic [ByteW-1:0]  acc_sum;
  logic [ByteW-1:0]  acc_xor;
  logic [IndexW-1:0] acc_idx;

  assign item_take_o = item_valid_i && (!out_valid_q || out_if.ready);

  assign d       = item_i.data_byte;
  assign acc_sum = running_sum_q + d;
  assign acc_xor = running_xor_q ^ d;
  assign acc_idx = byte_index_q + IndexW'(1);

  always_comb begin
    phase_d        = phase_q;
    byte_index_d   = byte_index_q;
    frame_length_d = frame_length_q;
    running_sum_d  = running_sum_q;
    running_xor_d  = running_xor_q;
    sum_failed_d   = sum_failed_q;
    emit           = 1'b0;
    verdict_d      = VERDICT_PASS;
    res_sum_d      = running_sum_q;
    res_xor_d      = running_xor_q;

    if (item_i.first_of_frame) begin
      byte_index_d   = '0;
      frame_length_d = '0;
      running_sum_d  = '0;
      running_xor_d  = '0;
      sum_failed_d   = 1'b0;
      if (d != cfg_i.start_byte) begin
        emit      = 1'b1;
        verdict_d = VERDICT_HDR;
        res_sum_d = '0;
        res_xor_d = '0;
        phase_d   = PH_IDLE;
      end else begin
        phase_d = PH_TYPE;
      end
    end else begin
      case (phase_q)
        PH_IDLE: ;
        PH_TYPE: begin
          if (d != cfg_i.type_byte) begin
            emit      = 1'b1;
            verdict_d = VERDICT_HDR;
            res_sum_d = '0;
            res_xor_d = '0;
            phase_d   = PH_IDLE;
          end else begin
            running_sum_d = d;
            running_xor_d = d;
            byte_index_d  = IndexW'(1);
            phase_d       = PH_LEN;
          end
        end
        PH_LEN: begin
          frame_length_d = d;
          if (d < ByteW'(2)) begin
            emit      = 1'b1;
            verdict_d = VERDICT_SHORT;
            phase_d   = PH_IDLE;
          end else begin
            running_sum_d = acc_sum;
            running_xor_d = acc_xor;
            byte_index_d  = acc_idx;
            phase_d       = (acc_idx >= {1'b0, d}) ? PH_SUM : PH_BODY;
          end
        end
        PH_BODY: begin
          running_sum_d = acc_sum;
          running_xor_d = acc_xor;
          byte_index_d  = acc_idx;
          if (acc_idx >= {1'b0, frame_length_q}) begin
            phase_d = PH_SUM;
          end
        end
        PH_SUM: begin
          sum_failed_d = (d != running_sum_q);
          phase_d      = PH_XOR;
        end
        PH_XOR: begin
          emit    = 1'b1;
          phase_d = PH_IDLE;
          if (sum_failed_q) begin
            verdict_d = VERDICT_SUM;
          end else if (d != running_xor_q) begin
            verdict_d = VERDICT_XOR;
          end else begin
            verdict_d = VERDICT_PASS;
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (item_take_o && emit) begin
      out_valid_d = 1'b1;
    end else if (out_if.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_IDLE;
      byte_index_q   <= '0;
      frame_length_q <= '0;
      running_sum_q  <= '0;
      running_xor_q  <= '0;
      sum_failed_q   <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (item_take_o) begin
        phase_q        <= phase_d;
        byte_index_q   <= byte_index_d;
        frame_length_q <= frame_length_d;
        running_sum_q  <= running_sum_d;
        running_xor_q  <= running_xor_d;
        sum_failed_q   <= sum_failed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_take_o && emit) begin
      verdict_q <= verdict_d;
      res_sum_q <= res_sum_d;
      res_xor_q <= res_xor_d;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.verdict      = verdict_q;
  assign out_if.computed_sum = res_sum_q;
  assign out_if.computed_xor = res_xor_q;

  a_emit_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_take_o && emit |=> phase_q == PH_IDLE)
    else $error("phase not idle after verdict");

  a_index_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_index_q[IndexW-1] == 1'b0)
    else $error("byte index beyond frame length range");

  a_trailer_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SUM || phase_q == PH_XOR) |-> byte_index_q >= {1'b0, frame_length_q})
    else $error("trailer reached before end of body");

  a_len_after_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_LEN |-> byte_index_q == IndexW'(1) && running_sum_q == running_xor_q)
    else $error("type byte not seeded into sum and xor");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_if.ready |=> out_valid_q && $stable(verdict_q))
    else $error("pending verdict lost");

endmodule

// File: sv/frame_sum_xor_checker_core.sv
// Frame sum/xor checker top level. A verdict is valid once the byte transaction
// causing it has passed the input register, then the result register.
// Throughput: one byte per cycle unless a verdict stalls (one sum/xor per byte).
// Reset (rst_ni, async, active low) returns the parser to idle, empties both
// registers and loads start byte 0x7E and type byte 0x0F.
module frame_sum_xor_checker_core
  import fsx_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  fsx_in_if.sink              in_if,
  fsx_out_if.source           out_if,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  cfg_t  cfg;
  logic  item_valid;
  item_t item;
  logic  item_take;

  fsx_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fsx_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_if        (in_if),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  fsx_frame_fsm u_frame_fsm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .out_if       (out_if)
  );

endmodule
